### src/e64tp_pkg.sv
// Shared types, constants and helper functions for the EUI-64 text parser.
// No dependencies; imported by e64tp_step, eui64_text_parser and tb.
package e64tp_pkg;

    // Text lengths and separator characters
    localparam logic [4:0] OCTET_TEXT_LEN = 5'd23;
    localparam logic [4:0] GROUP_TEXT_LEN = 5'd19;
    localparam logic [4:0] POS_SATURATE   = 5'd24;
    localparam logic [7:0] SEP_COLON      = 8'h3A;
    localparam logic [7:0] SEP_HYPHEN     = 8'h2D;

    // Result codes
    localparam logic STATUS_VALID   = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;
    localparam logic LAYOUT_OCTET   = 1'b0;
    localparam logic LAYOUT_GROUP   = 1'b1;

    // Per-string parse state
    typedef struct packed {
        logic [4:0]  pos;
        logic        octet_ok;
        logic        group_ok;
        logic [63:0] acc;
    } t_parse_state;

    // Result of one string
    typedef struct packed {
        logic [63:0] address;
        logic        status;
        logic        layout;
    } t_result;

    localparam t_parse_state PARSE_STATE_RESET = '{
        pos:      5'd0,
        octet_ok: 1'b1,
        group_ok: 1'b1,
        acc:      64'd0
    };

    // Separator slot of the octet layout: every third character
    function automatic logic is_octet_sep_pos(input logic [4:0] p);
        logic r;
        case (p)
            5'd2, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17, 5'd20: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    // Separator slot of the group layout: every fifth character
    function automatic logic is_group_sep_pos(input logic [4:0] p);
        logic r;
        case (p)
            5'd4, 5'd9, 5'd14: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

### src/e64tp_step.sv
// Per-character parse step: checks both layouts, shifts hex digits, forms the result.
// Depends on e64tp_pkg.
module e64tp_step (
    input  logic [7:0]             i_character,
    input  logic                   i_is_last,
    input  e64tp_pkg::t_parse_state i_state,
    output e64tp_pkg::t_parse_state o_state,
    output e64tp_pkg::t_result      o_result
);
    import e64tp_pkg::*;

    logic       is_hex;
    logic [3:0] nib;
    logic       is_colon;
    logic       is_hyphen;
    logic [4:0] pos_inc;
    logic       octet_ok;
    logic       group_ok;
    logic [63:0] acc;

    // Decode one hex digit, either letter case
    always_comb begin
        is_hex = 1'b1;
        nib    = 4'd0;
        if (i_character >= 8'h30 && i_character <= 8'h39) begin
            nib = i_character[3:0];
        end else if ((i_character >= 8'h61 && i_character <= 8'h66) ||
                     (i_character >= 8'h41 && i_character <= 8'h46)) begin
            nib = i_character[3:0] + 4'd9;
        end else begin
            is_hex = 1'b0;
        end
    end

    assign is_colon  = (i_character == SEP_COLON);
    assign is_hyphen = (i_character == SEP_HYPHEN);

    // Check the character against each layout
    always_comb begin
        octet_ok = i_state.octet_ok;
        if (i_state.pos >= OCTET_TEXT_LEN) begin
            octet_ok = 1'b0;
        end else if (is_octet_sep_pos(i_state.pos)) begin
            if (!is_colon && !is_hyphen) octet_ok = 1'b0;
        end else if (!is_hex) begin
            octet_ok = 1'b0;
        end

        group_ok = i_state.group_ok;
        if (i_state.pos >= GROUP_TEXT_LEN) begin
            group_ok = 1'b0;
        end else if (is_group_sep_pos(i_state.pos)) begin
            if (!is_colon) group_ok = 1'b0;
        end else if (!is_hex) begin
            group_ok = 1'b0;
        end
    end

    // Shift digits in, advance the saturating position
    assign acc     = is_hex ? {i_state.acc[59:0], nib} : i_state.acc;
    assign pos_inc = (i_state.pos < POS_SATURATE) ? i_state.pos + 5'd1 : POS_SATURATE;

    // Form the result and restart on the last character
    always_comb begin
        if (pos_inc == OCTET_TEXT_LEN && octet_ok) begin
            o_result = '{address: acc, status: STATUS_VALID, layout: LAYOUT_OCTET};
        end else if (pos_inc == GROUP_TEXT_LEN && group_ok) begin
            o_result = '{address: acc, status: STATUS_VALID, layout: LAYOUT_GROUP};
        end else begin
            o_result = '{address: 64'd0, status: STATUS_INVALID, layout: LAYOUT_OCTET};
        end

        if (i_is_last) begin
            o_state = PARSE_STATE_RESET;
        end else begin
            o_state = '{pos: pos_inc, octet_ok: octet_ok, group_ok: group_ok, acc: acc};
        end
    end

endmodule

### src/eui64_text_parser.sv
// EUI-64 text parser: one character a cycle while o_stall is low; o_valid rises once the last
// character has passed the input register, then the parse step into the result register.
// Throughput: one character per cycle; while a result waits, non-last requests still move
// and a last one holds in the input register, stalling the input until the result leaves.
// Reset (i_rst_n low, synchronous): both registers empty, parse state back to start.
// Top level; depends on e64tp_pkg and e64tp_step.
module eui64_text_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_character,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_address,
    output logic        o_status,
    output logic        o_layout
);
    import e64tp_pkg::*;

    logic         r_in_valid;
    logic [7:0]   r_in_char;
    logic         r_in_last;
    t_parse_state r_state;
    t_parse_state n_state;
    t_result      n_result;
    t_result      r_result;
    logic         r_out_valid;
    logic         out_free;
    logic         in_move;
    logic         in_free;

    // Flow control
    assign out_free = !r_out_valid || !i_stall;
    assign in_move  = r_in_valid && (!r_in_last || out_free);
    assign in_free  = !r_in_valid || in_move;
    assign o_stall  = !in_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_valid;
        end
        if (in_free && i_valid) begin
            r_in_char <= i_character;
            r_in_last <= i_is_last;
        end
    end

    e64tp_step u_step (
        .i_character (r_in_char),
        .i_is_last   (r_in_last),
        .i_state     (r_state),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PARSE_STATE_RESET;
        end else if (in_move) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= in_move && r_in_last;
        end
        if (out_free && in_move && r_in_last) begin
            r_result <= n_result;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_address = r_result.address;
    assign o_status  = r_result.status;
    assign o_layout  = r_result.layout;

`ifndef ASSERT_OFF
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pos <= POS_SATURATE)
        else $error("position count beyond saturation");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_move && r_in_last |=> r_state.pos == 5'd0 && r_state.octet_ok && r_state.group_ok)
        else $error("parse state not restarted after last character");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_result.status == STATUS_INVALID |->
            r_result.address == 64'd0 && r_result.layout == LAYOUT_OCTET)
        else $error("invalid result carries data");

    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid && !r_out_valid |-> !o_stall)
        else $error("stall raised while empty");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall |=> r_out_valid && $stable(r_result))
        else $error("stalled result lost or changed");
`endif

endmodule

### test/tb.sv
// Testbench for eui64_text_parser: directed address strings, then random text.
// Checks every result against its table entry or a local parser model; depends on e64tp_pkg and eui64_text_parser.
`timescale 1ns / 100ps

module tb;
    import e64tp_pkg::*;

    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_CHARS  = 130;
    localparam int MIN_RANDOM_STR = 6;
    localparam int DRAIN_EVERY   = 4;
    localparam int TAIL_CYCLES   = 10;
    localparam int IDLE_LIMIT    = 4000;

    // One directed string, with an optional byte patched in at one position
    typedef struct {
        string      text;
        int         patch_at;
        logic [7:0] patch_ch;
        bit         typed;
        t_result    want;
    } t_text_case;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_character = 8'h00;
    logic        i_is_last = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [63:0] o_address;
    logic        o_status;
    logic        o_layout;

    // Parser model state
    logic [4:0]  parse_pos = 5'd0;
    logic        fits_octet = 1'b1;
    logic        fits_group = 1'b1;
    logic [63:0] nibble_acc = 64'd0;

    t_result     pending_results[$];
    t_text_case  text_cases[$];
    logic [7:0]  text_buf[$];

    bit          no_idle = 1'b0;
    int          stall_left = 0;
    int          idle_cycles = 0;
    int          errors = 0;
    int          chars_sent = 0;
    int          strings_sent = 0;
    int          octet_seen = 0;
    int          group_seen = 0;
    int          rejected_seen = 0;

    eui64_text_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_character (i_character),
        .i_is_last   (i_is_last),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_address   (o_address),
        .o_status    (o_status),
        .o_layout    (o_layout)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] rand_hex_char();
        logic [3:0] v;
        v = 4'($urandom_range(0, 15));
        if (v < 4'd10) return 8'h30 + {4'h0, v};
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'h0, v} - 8'd10;
    endfunction

    // Decode one hex digit of either case; return 0 for any other byte
    function automatic logic hex_digit(input logic [7:0] ch, output logic [3:0] nib);
        nib = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            nib = 4'(ch - 8'h30);
            return 1'b1;
        end
        if (ch >= 8'h61 && ch <= 8'h66) begin
            nib = 4'(ch - 8'h61 + 8'd10);
            return 1'b1;
        end
        if (ch >= 8'h41 && ch <= 8'h46) begin
            nib = 4'(ch - 8'h41 + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the parser model by one character; fill res on the last one
    task automatic parse_char(input logic [7:0] ch, input logic last, output t_result res);
        logic [3:0] nib;
        logic       hex;
        hex = hex_digit(ch, nib);
        res = '0;

        // Octet layout: separator in every third slot
        if (parse_pos >= OCTET_TEXT_LEN) begin
            fits_octet = 1'b0;
        end else if (parse_pos % 3 == 2) begin
            if (ch != SEP_COLON && ch != SEP_HYPHEN) fits_octet = 1'b0;
        end else if (!hex) begin
            fits_octet = 1'b0;
        end

        // Group layout: colon in every fifth slot
        if (parse_pos >= GROUP_TEXT_LEN) begin
            fits_group = 1'b0;
        end else if (parse_pos % 5 == 4) begin
            if (ch != SEP_COLON) fits_group = 1'b0;
        end else if (!hex) begin
            fits_group = 1'b0;
        end

        if (hex) nibble_acc = {nibble_acc[59:0], nib};
        if (parse_pos < POS_SATURATE) parse_pos = parse_pos + 5'd1;

        if (last) begin
            if (parse_pos == OCTET_TEXT_LEN && fits_octet) begin
                res.address = nibble_acc;
                res.status  = STATUS_VALID;
                res.layout  = LAYOUT_OCTET;
            end else if (parse_pos == GROUP_TEXT_LEN && fits_group) begin
                res.address = nibble_acc;
                res.status  = STATUS_VALID;
                res.layout  = LAYOUT_GROUP;
            end else begin
                res.address = 64'd0;
                res.status  = STATUS_INVALID;
                res.layout  = LAYOUT_OCTET;
            end
            parse_pos  = 5'd0;
            fits_octet = 1'b1;
            fits_group = 1'b1;
            nibble_acc = 64'd0;
        end
    endtask

    // Offer one character after a random gap and hold it until accepted
    task automatic send_char(input logic [7:0] ch, input logic last,
                             input bit typed, input t_result want);
        int      gap;
        t_result res;
        gap = no_idle ? 0 : pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_character <= ch;
        i_is_last   <= last;
        do @(posedge i_clk); while (o_stall);
        chars_sent++;
        parse_char(ch, last, res);
        if (last) begin
            pending_results.push_back(typed ? want : res);
            strings_sent++;
        end
    endtask

    // Send the whole string held in text_buf
    task automatic send_text_buf(input bit typed, input t_result want);
        for (int i = 0; i < text_buf.size(); i++) begin
            send_char(text_buf[i], i == text_buf.size() - 1, typed, want);
        end
    endtask

    // Hold the sender until every expected result has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic add_case(input string text, input int patch_at, input logic [7:0] patch_ch,
                            input bit typed, input logic [63:0] addr,
                            input logic status, input logic layout);
        t_text_case c;
        c.text          = text;
        c.patch_at      = patch_at;
        c.patch_ch      = patch_ch;
        c.typed         = typed;
        c.want.address  = addr;
        c.want.status   = status;
        c.want.layout   = layout;
        text_cases.push_back(c);
    endtask

    // Fill text_buf with a well-formed address, a damaged one, or noise
    task automatic build_random_text();
        int r;
        int len;
        int pos;
        r = $urandom_range(0, 99);
        text_buf.delete();
        if (r < 70) begin
            if (r < 40) begin
                for (int i = 0; i < OCTET_TEXT_LEN; i++) begin
                    if (i % 3 == 2) text_buf.push_back($urandom_range(0, 1) ? SEP_COLON
                                                                            : SEP_HYPHEN);
                    else text_buf.push_back(rand_hex_char());
                end
            end else begin
                for (int i = 0; i < GROUP_TEXT_LEN; i++) begin
                    if (i % 5 == 4) text_buf.push_back(SEP_COLON);
                    else text_buf.push_back(rand_hex_char());
                end
            end
            // Damage about a quarter of the well-formed strings
            if ($urandom_range(0, 3) == 0) begin
                pos = $urandom_range(0, text_buf.size() - 1);
                case ($urandom_range(0, 3))
                    0: text_buf[pos] = 8'($urandom_range(0, 255));
                    1: void'(text_buf.pop_back());
                    2: text_buf.push_back(rand_hex_char());
                    default: text_buf[pos] = rand_hex_char();
                endcase
            end
        end else begin
            len = $urandom_range(1, 40);
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: text_buf.push_back(8'($urandom_range(0, 255)));
                    5, 6, 7:       text_buf.push_back(rand_hex_char());
                    8:             text_buf.push_back(SEP_COLON);
                    default:       text_buf.push_back(SEP_HYPHEN);
                endcase
            end
        end
    endtask

    // Receiver: one open cycle, then a random stall stretch that may be empty; no stall while no_idle is set
    always @(posedge i_clk) begin
        if (no_idle) begin
            i_stall <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
            stall_left = pick_gap();
        end
    end

    // Compare each accepted result with the oldest expected one
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: address %h status %b layout %b",
                       o_address, o_status, o_layout);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_address !== want.address) begin
                    $error("address: expected %h, got %h", want.address, o_address);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %b, got %b", want.status, o_status);
                    errors++;
                end
                if (o_layout !== want.layout) begin
                    $error("layout: expected %b, got %b", want.layout, o_layout);
                    errors++;
                end
                if (want.status == STATUS_INVALID) rejected_seen++;
                else if (want.layout == LAYOUT_GROUP) group_seen++;
                else octet_seen++;
            end
        end
    end

    // Watchdog: end the run if nothing moves on either side for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: %0d results still expected", pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int      rand_chars_start;
        int      rand_strings;
        t_result none;
        none = '0;
        rand_strings = 0;

        // Extremes, both layouts, case and separator mix
        add_case("00-00-00-00-00-00-00-00", -1, 8'h00, 1, 64'd0, STATUS_VALID, LAYOUT_OCTET);
        add_case("FF:FF:FF:FF:FF:FF:FF:FF", -1, 8'h00, 1, '1, STATUS_VALID, LAYOUT_OCTET);
        add_case("0000:0000:0000:0000", -1, 8'h00, 1, 64'd0, STATUS_VALID, LAYOUT_GROUP);
        add_case("ffff:ffff:ffff:ffff", -1, 8'h00, 1, '1, STATUS_VALID, LAYOUT_GROUP);
        add_case("aB-cD:eF-01:23-45:67-89", -1, 8'h00, 0, 64'd0, STATUS_VALID, LAYOUT_OCTET);
        add_case("0123:4567:89ab:CDEF", -1, 8'h00, 0, 64'd0, STATUS_VALID, LAYOUT_GROUP);
        // Wrong lengths: one short, one long, far over, a single character
        add_case("01-23-45-67-89-ab-cd-e", -1, 8'h00, 1, 64'd0, STATUS_INVALID, LAYOUT_OCTET);
        add_case("01-23-45-67-89-ab-cd-ef0", -1, 8'h00, 1, 64'd0, STATUS_INVALID,
                 LAYOUT_OCTET);
        add_case("0123456789abcdef0123456789abcdef", -1, 8'h00, 1, 64'd0, STATUS_INVALID,
                 LAYOUT_OCTET);
        add_case("0", -1, 8'h00, 1, 64'd0, STATUS_INVALID, LAYOUT_OCTET);
        // Bad digit, bad separators, group length with octet layout, separators out of place
        add_case("01-23-45-67-89-ab-cd-eg", -1, 8'h00, 1, 64'd0, STATUS_INVALID,
                 LAYOUT_OCTET);
        add_case("01-23-45-67.89-ab-cd-ef", -1, 8'h00, 1, 64'd0, STATUS_INVALID,
                 LAYOUT_OCTET);
        add_case("0123-4567-89ab-cdef", -1, 8'h00, 1, 64'd0, STATUS_INVALID, LAYOUT_OCTET);
        add_case("01-23-45-67-89-ab-c", -1, 8'h00, 1, 64'd0, STATUS_INVALID, LAYOUT_OCTET);
        add_case("01:23:45:67:89:ab:c:d", -1, 8'h00, 1, 64'd0, STATUS_INVALID, LAYOUT_OCTET);
        // NUL and high bytes count as plain non-hex characters
        add_case("01-23-45-67-89-ab-cd-ef", 4, 8'h00, 1, 64'd0, STATUS_INVALID,
                 LAYOUT_OCTET);
        add_case("0123:4567:89ab:cdef", 0, 8'hC1, 1, 64'd0, STATUS_INVALID, LAYOUT_OCTET);
        add_case("0123:4567:89ab:cdef", 9, 8'hFF, 1, 64'd0, STATUS_INVALID, LAYOUT_OCTET);

        // Hold reset, then release it
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (text_cases[k]) begin
            text_buf.delete();
            for (int i = 0; i < text_cases[k].text.len(); i++) begin
                if (i == text_cases[k].patch_at) text_buf.push_back(text_cases[k].patch_ch);
                else text_buf.push_back(text_cases[k].text[i]);
            end
            send_text_buf(text_cases[k].typed, text_cases[k].want);
        end
        drain_results();

        // Random strings, with idle-free stretches and periodic drains
        rand_chars_start = chars_sent;
        while (chars_sent - rand_chars_start < RANDOM_CHARS || rand_strings < MIN_RANDOM_STR)
        begin
            if (rand_strings % 3 == 0) no_idle = ($urandom_range(0, 3) == 0);
            build_random_text();
            send_text_buf(1'b0, none);
            rand_strings++;
            if (rand_strings % DRAIN_EVERY == 0) drain_results();
        end
        no_idle = 1'b0;

        // Wait out the remaining results and the pipeline
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d strings in %0d characters, directed and random.",
                 strings_sent, chars_sent);
        $display("Results: %0d octet form, %0d group form, %0d rejected.",
                 octet_seen, group_seen, rejected_seen);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
